// ===== design/icmb_pkg.sv =====
package icmb_pkg;

    // frame geometry limits
    localparam int MAX_ROW_LENGTH = 512;
    localparam int MAX_ROWS       = 1024;

    // register field widths
    localparam int ROW_LEN_W  = 10;
    localparam int ROW_CNT_W  = 11;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 11;

    // internal widths derived from the limits
    localparam int ADDR_W    = $clog2(MAX_ROW_LENGTH);
    localparam int ROW_IDX_W = $clog2(MAX_ROWS + 1);

    // pixel word, red in the low byte, blue in the high byte
    localparam int CHAN_W  = 8;
    localparam int PIXEL_W = 3 * CHAN_W;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_LENGTH = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT  = 1'b1;

    // register reset values
    localparam logic [ROW_LEN_W-1:0] ROW_LENGTH_RESET = 10'd500;
    localparam logic [ROW_CNT_W-1:0] ROW_COUNT_RESET  = 11'd500;

    // 1/5 as a 16-bit fraction, rounded up; exact floor for sums up to 5*255
    localparam logic [13:0] RECIP_FIVE = 14'd13108;

    typedef logic [PIXEL_W-1:0] pixel_t;

    // control of the item held in the compute stage
    typedef struct packed {
        logic emit;      // produces a result
        logic wr_in;     // raw pixel goes into the delay line
        logic use_mean;  // result is the five point mean
        logic last;      // final pixel of the frame
    } icmb_ctrl_t;

endpackage

// ===== design/inplace_cross_mean_blur.sv =====
// channel | dir | handshake          | payload
// --------+-----+--------------------+------------------------------------------
// s_      | in  | s_tvalid/s_tready  | s_tdata: red, green, blue; s_tuser: req_type
// m_      | out | m_tvalid/m_tready  | m_tdata: red, green, blue; m_tlast: frame_last
// cfg_    | in  | cfg_we             | cfg_addr: register index; cfg_wdata: value
//
// one transaction per clock sustained while m_ takes the results; a result passes
// the line memory read, then the mean and the output register
// the raw delay line has two registered reads and one write each cycle, the
// filtered store one registered read and one write
// reset is synchronous on aresetn; the line memories are not cleared
// s_tready falls only while the compute stage holds a result that m_ cannot take
module inplace_cross_mean_blur
    import icmb_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [PIXEL_W-1:0]    s_tdata,   // in_red, in_green, in_blue
    input  logic                  s_tuser,   // req_type
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [PIXEL_W-1:0]    m_tdata,   // out_red, out_green, out_blue
    output logic                  m_tlast,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    // configuration and frame position
    logic [ROW_LEN_W-1:0] row_length_reg;
    logic [ROW_CNT_W-1:0] row_count_reg;
    logic [ADDR_W-1:0]    ring_reg, ring_next;
    logic [ROW_IDX_W-1:0] row_reg, row_next;
    logic [ADDR_W-1:0]    drain_reg, drain_next;

    // compute stage
    logic       s2_valid_reg, s2_valid_next;
    icmb_ctrl_t s2_ctrl_reg, s2_ctrl_next;
    logic [ADDR_W-1:0] s2_addr_reg;
    pixel_t     s2_cur_reg;
    pixel_t     in_a_reg, in_b_reg, out_q_reg;
    pixel_t     left_reg;

    // output register
    logic   out_valid_reg, out_valid_next;
    pixel_t out_data_reg;
    logic   out_last_reg;

    // line memories
    pixel_t input_delay_line [MAX_ROW_LENGTH];
    pixel_t output_line_store [MAX_ROW_LENGTH];

    logic [ROW_LEN_W-1:0] eff_len;
    logic [ROW_IDX_W-1:0] eff_rows;
    logic [ADDR_W-1:0]    len_m1;
    logic                 frame_done;
    logic                 s_accept;
    logic                 s2_adv;
    logic                 rd_en;
    logic [ADDR_W-1:0]    rd_addr_a, rd_addr_b;
    pixel_t               mean_res, s2_res;

    // saturated geometry
    always_comb begin
        if (row_length_reg < ROW_LEN_W'(2)) begin
            eff_len = ROW_LEN_W'(2);
        end else if (row_length_reg > ROW_LEN_W'(MAX_ROW_LENGTH)) begin
            eff_len = ROW_LEN_W'(MAX_ROW_LENGTH);
        end else begin
            eff_len = row_length_reg;
        end
        if (row_count_reg < ROW_CNT_W'(3)) begin
            eff_rows = ROW_IDX_W'(3);
        end else if (row_count_reg > ROW_CNT_W'(MAX_ROWS)) begin
            eff_rows = ROW_IDX_W'(MAX_ROWS);
        end else begin
            eff_rows = ROW_IDX_W'(row_count_reg);
        end
    end

    assign len_m1     = ADDR_W'(eff_len - ROW_LEN_W'(1));
    assign frame_done = (row_reg == eff_rows);

    // handshake: the compute stage moves unless its result is blocked
    assign s2_adv   = s2_valid_reg && (!s2_ctrl_reg.emit || !out_valid_reg || m_tready);
    assign s_tready = !s2_valid_reg || s2_adv;
    assign s_accept = s_tvalid && s_tready;

    // decode of the accepted transaction
    always_comb begin
        ring_next     = ring_reg;
        row_next      = row_reg;
        drain_next    = drain_reg;
        s2_ctrl_next  = '0;
        rd_en         = 1'b0;
        rd_addr_a     = ring_reg;
        rd_addr_b     = (ring_reg == len_m1) ? '0 : ring_reg + ADDR_W'(1);
        s2_valid_next = s2_adv ? 1'b0 : s2_valid_reg;
        if (cfg_we) begin
            ring_next  = '0;
            row_next   = '0;
            drain_next = '0;
        end else if (s_accept) begin
            if (s_tuser) begin
                // drain one held pixel of the last row
                if (frame_done) begin
                    rd_en              = 1'b1;
                    rd_addr_a          = drain_reg;
                    s2_valid_next      = 1'b1;
                    s2_ctrl_next.emit  = 1'b1;
                    s2_ctrl_next.last  = (drain_reg == len_m1);
                    if (drain_reg == len_m1) begin
                        ring_next  = '0;
                        row_next   = '0;
                        drain_next = '0;
                    end else begin
                        drain_next = drain_reg + ADDR_W'(1);
                    end
                end
            end else if (!frame_done) begin
                // arriving pixel
                rd_en                 = 1'b1;
                s2_valid_next         = 1'b1;
                s2_ctrl_next.wr_in    = 1'b1;
                s2_ctrl_next.emit     = (row_reg != '0);
                s2_ctrl_next.use_mean = (row_reg > ROW_IDX_W'(1));
                if (ring_reg == len_m1) begin
                    ring_next = '0;
                    row_next  = row_reg + ROW_IDX_W'(1);
                end else begin
                    ring_next = ring_reg + ADDR_W'(1);
                end
            end
        end
    end

    // truncating mean of five pixels, per channel, by reciprocal multiply
    function automatic pixel_t mean5(pixel_t a, pixel_t b, pixel_t c, pixel_t d, pixel_t e);
        logic [10:0] sum;
        logic [24:0] prod;
        pixel_t      res;
        res = '0;
        for (int ch = 0; ch < 3; ch++) begin
            sum = 11'(a[ch*CHAN_W +: CHAN_W]) + 11'(b[ch*CHAN_W +: CHAN_W])
                + 11'(c[ch*CHAN_W +: CHAN_W]) + 11'(d[ch*CHAN_W +: CHAN_W])
                + 11'(e[ch*CHAN_W +: CHAN_W]);
            prod = 25'(sum) * 25'(RECIP_FIVE);
            res[ch*CHAN_W +: CHAN_W] = prod[16 +: CHAN_W];
        end
        return res;
    endfunction

    // result of the compute stage
    assign mean_res = mean5(in_a_reg, in_b_reg, s2_cur_reg, out_q_reg, left_reg);
    assign s2_res   = s2_ctrl_reg.use_mean ? mean_res : in_a_reg;

    // output register
    always_comb begin
        out_valid_next = out_valid_reg;
        if (s2_adv && s2_ctrl_reg.emit) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_length_reg <= ROW_LENGTH_RESET;
            row_count_reg  <= ROW_COUNT_RESET;
            ring_reg       <= '0;
            row_reg        <= '0;
            drain_reg      <= '0;
            s2_valid_reg   <= 1'b0;
            s2_ctrl_reg    <= '0;
            out_valid_reg  <= 1'b0;
        end else begin
            if (cfg_we && cfg_addr == CFG_ROW_LENGTH) begin
                row_length_reg <= cfg_wdata[ROW_LEN_W-1:0];
            end
            if (cfg_we && cfg_addr == CFG_ROW_COUNT) begin
                row_count_reg <= cfg_wdata[ROW_CNT_W-1:0];
            end
            ring_reg      <= ring_next;
            row_reg       <= row_next;
            drain_reg     <= drain_next;
            s2_valid_reg  <= s2_valid_next;
            if (s_accept) begin
                s2_ctrl_reg <= s2_ctrl_next;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s2_addr_reg <= ring_reg;
            s2_cur_reg  <= s_tdata;
        end
        if (s2_adv && s2_ctrl_reg.emit && s2_ctrl_reg.wr_in) begin
            left_reg <= s2_res;
        end
        if (s2_adv && s2_ctrl_reg.emit) begin
            out_data_reg <= s2_res;
            out_last_reg <= s2_ctrl_reg.last;
        end
    end

    // raw delay line: write from the compute stage, reads forward that write
    always_ff @(posedge aclk) begin
        if (s2_adv && s2_ctrl_reg.wr_in) begin
            input_delay_line[s2_addr_reg] <= s2_cur_reg;
        end
        if (rd_en) begin
            if (s2_adv && s2_ctrl_reg.wr_in && rd_addr_a == s2_addr_reg) begin
                in_a_reg <= s2_cur_reg;
            end else begin
                in_a_reg <= input_delay_line[rd_addr_a];
            end
            if (s2_adv && s2_ctrl_reg.wr_in && rd_addr_b == s2_addr_reg) begin
                in_b_reg <= s2_cur_reg;
            end else begin
                in_b_reg <= input_delay_line[rd_addr_b];
            end
        end
    end

    // filtered line store: the row above is always written well before it is read
    always_ff @(posedge aclk) begin
        if (s2_adv && s2_ctrl_reg.emit && s2_ctrl_reg.wr_in) begin
            output_line_store[s2_addr_reg] <= s2_res;
        end
        if (rd_en) begin
            out_q_reg <= output_line_store[rd_addr_a];
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

    // checks on the block's own control
    a_stuck_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        s2_valid_reg && !s2_adv |-> !s_tready)
        else $error("transaction taken while compute stage is blocked");

    a_last_is_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        s2_valid_reg && s2_ctrl_reg.last |-> s2_ctrl_reg.emit && !s2_ctrl_reg.wr_in)
        else $error("frame end flagged on a pixel arrival");

    a_ring_in_row: assert property (@(posedge aclk) disable iff (!aresetn)
        ADDR_W'(ring_reg) <= len_m1 && drain_reg <= len_m1)
        else $error("column pointer beyond row length");

    a_row_in_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        row_reg <= eff_rows)
        else $error("row index beyond frame");

    a_mean_after_two_rows: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept && !s_tuser && !frame_done && row_reg < ROW_IDX_W'(2)
        |=> !s2_ctrl_reg.use_mean)
        else $error("mean used in the first two rows");

endmodule
